// ----- rtl/core/echo_pulse_capture_proximity_alarm_defines.svh -----
// Assertion macros for the echo pulse capture block.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ECHO_PULSE_CAPTURE_PROXIMITY_ALARM_DEFINES_SVH
`define ECHO_PULSE_CAPTURE_PROXIMITY_ALARM_DEFINES_SVH

`ifndef SYNTH

`define EPCPA_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("epcpa assertion failed");

`define EPCPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("epcpa assertion failed");

`define EPCPA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("epcpa assertion failed");

`else

`define EPCPA_ASSERT(label, prop)

`define EPCPA_ASSERT_NEXT(label, ante, cons)

`define EPCPA_ASSERT_SAME(label, ante, cons)

`endif

`endif

// ----- rtl/core/epcpa_pkg.sv -----
package epcpa_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned OvfW   = 6;
  localparam int unsigned WidthW = OvfW + CountW;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [OvfW-1:0]   OVF_MAX     = 6'h3F;
  localparam logic [CountW-1:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [WidthW-1:0] NEAR_RESET  = 22'd59;
  localparam logic [WidthW-1:0] ALARM_RESET = 22'd588;

  // function codes of an input word
  localparam logic FUNC_EVENT = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_NEAR_LIMIT  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_ALARM_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    ZONE_NONE  = 2'd0,
    ZONE_NEAR  = 2'd1,
    ZONE_ALARM = 2'd2,
    ZONE_FAR   = 2'd3
  } zone_e;

  typedef struct packed {
    logic              func;
    logic              overflow_event;
    logic              edge_event;
    logic [CountW-1:0] capture_count;
  } item_t;

  typedef struct packed {
    logic              measure_done;
    logic [WidthW-1:0] pulse_width;
    zone_e             zone;
    logic              alarm_on;
    logic              waiting_fall;
  } result_t;

endpackage

// ----- rtl/core/epcpa_ifs.sv -----
interface epcpa_in_if;
  import epcpa_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic              overflow_event;
  logic              edge_event;
  logic [CountW-1:0] capture_count;

  modport source (
    output valid, func, overflow_event, edge_event, capture_count,
    input  ready
  );

  modport sink (
    input  valid, func, overflow_event, edge_event, capture_count,
    output ready
  );
endinterface

interface epcpa_out_if;
  import epcpa_pkg::*;

  logic              valid;
  logic              ready;
  logic              measure_done;
  logic [WidthW-1:0] pulse_width;
  logic [1:0]        zone;
  logic              alarm_on;
  logic              waiting_fall;

  modport source (
    output valid, measure_done, pulse_width, zone, alarm_on, waiting_fall,
    input  ready
  );

  modport sink (
    input  valid, measure_done, pulse_width, zone, alarm_on, waiting_fall,
    output ready
  );
endinterface

// ----- rtl/core/epcpa_capture.sv -----
module epcpa_capture (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  epcpa_pkg::item_t              item_i,
  input  logic [epcpa_pkg::WidthW-1:0]  near_limit_i,
  input  logic [epcpa_pkg::WidthW-1:0]  alarm_limit_i,
  output epcpa_pkg::result_t            result_o
);
  import epcpa_pkg::*;

  logic              done_q, done_d;
  logic              capt_q, capt_d;
  logic [OvfW-1:0]   ovf_q, ovf_d;
  logic [CountW-1:0] held_q, held_d;
  logic              alarm_q, alarm_d;
  logic [WidthW-1:0] width_cur;

  assign width_cur = {ovf_q, held_q};

  always_comb begin
    done_d = done_q;
    capt_d = capt_q;
    ovf_d  = ovf_q;
    held_d = held_q;
    alarm_d = alarm_q;
    result_o = '0;
    result_o.zone = ZONE_NONE;

    if (item_i.func == FUNC_EVENT) begin
      // a finished capture ignores further timer events
      if (!done_q) begin
        if (item_i.overflow_event && capt_q) begin
          if (ovf_q == OVF_MAX) begin
            done_d = 1'b1;
            held_d = COUNT_MAX;
          end else begin
            ovf_d = ovf_q + OvfW'(1);
          end
        end
        if (item_i.edge_event && !done_d) begin
          if (capt_q) begin
            done_d = 1'b1;
            held_d = item_i.capture_count;
          end else begin
            ovf_d  = '0;
            held_d = '0;
            capt_d = 1'b1;
          end
        end
      end
      result_o.measure_done = done_d;
      if (done_d) begin
        result_o.pulse_width = {ovf_d, held_d};
      end
    end else begin
      result_o.measure_done = done_q;
      if (done_q) begin
        result_o.pulse_width = width_cur;
        // near limit has priority when the limits are out of order
        if (width_cur < near_limit_i) begin
          result_o.zone = ZONE_NEAR;
          alarm_d = 1'b0;
        end else if (width_cur < alarm_limit_i) begin
          result_o.zone = ZONE_ALARM;
          alarm_d = 1'b1;
        end else begin
          result_o.zone = ZONE_FAR;
          alarm_d = 1'b0;
        end
      end
      done_d = 1'b0;
      capt_d = 1'b0;
      ovf_d  = '0;
    end

    result_o.alarm_on     = alarm_d;
    result_o.waiting_fall = capt_d && !done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      capt_q  <= 1'b0;
      ovf_q   <= '0;
      held_q  <= '0;
      alarm_q <= 1'b0;
    end else if (fire_i) begin
      done_q  <= done_d;
      capt_q  <= capt_d;
      ovf_q   <= ovf_d;
      held_q  <= held_d;
      alarm_q <= alarm_d;
    end
  end

endmodule

// ----- rtl/core/echo_pulse_capture_proximity_alarm.sv -----
// Channel  Dir  Word fields
// evt_i    in   func, overflow_event, edge_event, capture_count[15:0]
// res_o    out  measure_done, pulse_width[21:0], zone[1:0], alarm_on, waiting_fall
// cfg      in   cfg_we_i, cfg_idx_i (0 near_limit, 1 alarm_limit), cfg_data_i[21:0]
//
// One word per cycle while res_o is not stalled; each word passes through the input
// register and then sits in the result register.
// The capture state updates as a word moves from input to result register.
// Reset clears the capture state and the alarm; limits return to 59 and 588.
// A stalled result holds the input register; evt_i.ready drops only then.
`include "echo_pulse_capture_proximity_alarm_defines.svh"

module echo_pulse_capture_proximity_alarm (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  epcpa_in_if.sink                       evt_i,
  epcpa_out_if.source                    res_o,
  input  logic                           cfg_we_i,
  input  logic [epcpa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [epcpa_pkg::WidthW-1:0]   cfg_data_i
);
  import epcpa_pkg::*;

  logic [WidthW-1:0] near_limit_q;
  logic [WidthW-1:0] alarm_limit_q;

  logic    s1_valid_q;
  item_t   s1_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  result_t calc_res;
  logic    s1_adv;
  logic    in_fire;

  assign s1_adv  = s1_valid_q && (!out_valid_q || res_o.ready);
  assign evt_i.ready = !s1_valid_q || s1_adv;
  assign in_fire = evt_i.valid && evt_i.ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_limit_q  <= NEAR_RESET;
      alarm_limit_q <= ALARM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NEAR_LIMIT:  near_limit_q  <= cfg_data_i;
        CFG_ALARM_LIMIT: alarm_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      s1_valid_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q.func           <= evt_i.func;
      s1_item_q.overflow_event <= evt_i.overflow_event;
      s1_item_q.edge_event     <= evt_i.edge_event;
      s1_item_q.capture_count  <= evt_i.capture_count;
    end
  end

  epcpa_capture u_capture (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (s1_adv),
    .item_i        (s1_item_q),
    .near_limit_i  (near_limit_q),
    .alarm_limit_i (alarm_limit_q),
    .result_o      (calc_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || res_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_res_q <= calc_res;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.measure_done = out_res_q.measure_done;
  assign res_o.pulse_width  = out_res_q.pulse_width;
  assign res_o.zone         = out_res_q.zone;
  assign res_o.alarm_on     = out_res_q.alarm_on;
  assign res_o.waiting_fall = out_res_q.waiting_fall;

  `EPCPA_ASSERT_SAME(a_done_not_waiting, res_o.valid,
                     !(res_o.measure_done && res_o.waiting_fall))
  `EPCPA_ASSERT_SAME(a_zone_needs_done, res_o.valid && res_o.zone != ZONE_NONE,
                     res_o.measure_done)
  `EPCPA_ASSERT_SAME(a_width_zero_idle, res_o.valid && !res_o.measure_done,
                     res_o.pulse_width == '0)
  `EPCPA_ASSERT_NEXT(a_stall_holds_s1, s1_valid_q && !s1_adv, s1_valid_q)
  `EPCPA_ASSERT_SAME(a_adv_fills_out, s1_adv, !out_valid_q || res_o.ready)

endmodule
